>>> hw/rtl/esr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// esr_pkg: shared types and constants of the escaped subpacket receiver
// Line event codes, result status codes, per-subpacket state, the CRC-16
// byte update and the unescape constants.
// ----------------------------------------------------------------------------
package esr_pkg;

  // field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned STAT_W  = 4;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned CRC_W   = 16;

  // reset value of max_length and the hard cap on data bytes per subpacket
  localparam logic [COUNT_W-1:0] MAX_LENGTH_RESET = 11'd1024;
  localparam logic [COUNT_W-1:0] MAX_SUBPACKET    = 11'd1024;

  // escape byte and escape codes
  localparam logic [BYTE_W-1:0] ESC_BYTE   = 8'h18;
  localparam logic [5:0]        END_PREFIX = 6'b011010;  // 0x68..0x6b
  localparam logic [BYTE_W-1:0] CODE_RUB0  = 8'h6c;
  localparam logic [BYTE_W-1:0] CODE_RUB1  = 8'h6d;
  localparam logic [BYTE_W-1:0] VAL_RUB0   = 8'h7f;
  localparam logic [BYTE_W-1:0] VAL_RUB1   = 8'hff;
  localparam logic [BYTE_W-1:0] CLASS_MASK = 8'h60;
  localparam logic [BYTE_W-1:0] CLASS_CTRL = 8'h40;
  localparam logic [BYTE_W-1:0] CTRL_XOR   = 8'h40;

  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

  typedef enum logic [OP_W-1:0] {
    OP_BYTE    = 2'd0,
    OP_TIMEOUT = 2'd1,
    OP_CARRIER = 2'd2,
    OP_UNUSED  = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DATA    = 4'd0,
    ST_CRCE    = 4'd1,
    ST_CRCG    = 4'd2,
    ST_CRCQ    = 4'd3,
    ST_CRCW    = 4'd4,
    ST_BADCRC  = 4'd5,
    ST_LONG    = 4'd6,
    ST_CANCEL  = 4'd7,
    ST_TIMEOUT = 4'd8,
    ST_CARRIER = 4'd9,
    ST_BADESC  = 4'd10
  } status_t;

  typedef enum logic [1:0] {
    PH_DATA     = 2'd0,
    PH_DATA_ESC = 2'd1,
    PH_CRC      = 2'd2,
    PH_CRC_ESC  = 2'd3
  } phase_t;

  // per-subpacket receive state
  typedef struct packed {
    phase_t             phase;
    logic [1:0]         cancel_run;
    logic [CRC_W-1:0]   crc;
    logic [COUNT_W-1:0] count;
    logic [1:0]         end_kind;
    logic               crc_seen;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:      PH_DATA,
    cancel_run: 2'd0,
    crc:        '0,
    count:      '0,
    end_kind:   2'd0,
    crc_seen:   1'b0
  };

  // one result transaction
  typedef struct packed {
    logic               valid;
    status_t            status;
    logic [BYTE_W-1:0]  data;
    logic [COUNT_W-1:0] count;
    logic               last;
  } result_t;

  // crc-16 update by one byte, msb first
  function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc_in,
                                                 input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/esr_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// esr_step: one line event through the receive state
// Unescapes the byte, tracks cancel runs, updates CRC and byte count and
// forms the result transaction together with the next state.
// ----------------------------------------------------------------------------
module esr_step (
  input  wire esr_pkg::op_t                     op,
  input  wire logic [esr_pkg::BYTE_W-1:0]       line_byte,
  input  wire logic [esr_pkg::COUNT_W-1:0]      max_length,
  input  wire esr_pkg::state_t                  st,
  output esr_pkg::state_t                       st_nxt,
  output esr_pkg::result_t                      res
);
  import esr_pkg::*;

  logic               in_crc;
  logic               esc_ph;
  logic               fin;
  status_t            fin_st;
  logic               sym_go;
  logic               sym_end;
  logic               sym_bad;
  logic [BYTE_W-1:0]  sym_val;
  logic [CRC_W-1:0]   crc_fed;
  logic [COUNT_W-1:0] limit;

  // effective byte limit
  assign limit = (max_length > MAX_SUBPACKET) ? MAX_SUBPACKET : max_length;

  assign in_crc  = (st.phase == PH_CRC) || (st.phase == PH_CRC_ESC);
  assign esc_ph  = (st.phase == PH_DATA_ESC) || (st.phase == PH_CRC_ESC);
  assign crc_fed = crc_feed(st.crc, sym_val);

  // escape decode and cancel tracking
  always_comb begin
    fin     = 1'b0;
    fin_st  = ST_DATA;
    sym_go  = 1'b0;
    sym_end = 1'b0;
    sym_bad = 1'b0;
    sym_val = line_byte;
    st_nxt  = st;
    res     = '{valid: 1'b0, status: ST_DATA, data: '0, count: st.count, last: 1'b0};

    unique case (op)
      OP_TIMEOUT: begin
        fin    = 1'b1;
        fin_st = ST_TIMEOUT;
      end
      OP_CARRIER: begin
        fin    = 1'b1;
        fin_st = ST_CARRIER;
      end
      OP_BYTE: begin
        if (esc_ph) begin
          if (line_byte == ESC_BYTE) begin
            if (st.cancel_run == 2'd3) begin
              fin    = 1'b1;
              fin_st = ST_CANCEL;
            end else begin
              st_nxt.cancel_run = st.cancel_run + 2'd1;
            end
          end else begin
            st_nxt.cancel_run = 2'd0;
            sym_go            = 1'b1;
            priority if (line_byte[7:2] == END_PREFIX) begin
              sym_end = 1'b1;
            end else if (line_byte == CODE_RUB0) begin
              sym_val = VAL_RUB0;
            end else if (line_byte == CODE_RUB1) begin
              sym_val = VAL_RUB1;
            end else if ((line_byte & CLASS_MASK) == CLASS_CTRL) begin
              sym_val = line_byte ^ CTRL_XOR;
            end else begin
              sym_bad = 1'b1;
            end
          end
        end else if (line_byte == ESC_BYTE) begin
          st_nxt.phase      = in_crc ? PH_CRC_ESC : PH_DATA_ESC;
          st_nxt.cancel_run = 2'd0;
        end else begin
          sym_go = 1'b1;
        end
      end
      default: begin
        // unused event code leaves everything alone
      end
    endcase

    // symbol handling: bad escape, end code, crc byte or data byte
    if (sym_go) begin
      priority if (sym_bad) begin
        fin    = 1'b1;
        fin_st = ST_BADESC;
      end else if (sym_end) begin
        st_nxt.crc      = crc_fed;
        st_nxt.end_kind = line_byte[1:0];
        st_nxt.crc_seen = 1'b0;
        st_nxt.phase    = PH_CRC;
      end else if (in_crc) begin
        st_nxt.crc   = crc_fed;
        st_nxt.phase = PH_CRC;
        if (!st.crc_seen) begin
          st_nxt.crc_seen = 1'b1;
        end else if (crc_fed != '0) begin
          fin    = 1'b1;
          fin_st = ST_BADCRC;
        end else begin
          fin    = 1'b1;
          fin_st = status_t'(STAT_W'(st.end_kind) + STAT_W'(1));
        end
      end else begin
        st_nxt.phase = PH_DATA;
        if (st.count >= limit) begin
          fin    = 1'b1;
          fin_st = ST_LONG;
        end else begin
          st_nxt.count = st.count + COUNT_W'(1);
          st_nxt.crc   = crc_fed;
          res = '{valid: 1'b1, status: ST_DATA, data: sym_val,
                  count: st.count + COUNT_W'(1), last: 1'b0};
        end
      end
    end

    // end of subpacket: report and clear
    if (fin) begin
      res    = '{valid: 1'b1, status: fin_st, data: '0, count: st.count, last: 1'b1};
      st_nxt = STATE_RESET;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/escaped_subpacket_receiver_top.sv
// path: each input transaction passes the input register and the step logic
//   on its way into the result register; no result for escape bytes, counted
//   cancel bytes, end codes and the first crc byte
// throughput: one line event per cycle while the result register is empty or out_ready is high
// reset: synchronous active-low rst_n clears all subpacket state and both
//   valid flags, and sets max_length to 1024
`default_nettype none
// ----------------------------------------------------------------------------
// escaped_subpacket_receiver_top: escaped data subpacket receiver
// Input register, single-pass step logic with the subpacket state, and a
// result register; crc-16 checked over data, end code and crc bytes.
// ----------------------------------------------------------------------------
module escaped_subpacket_receiver_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [10:0] cfg_wr_data,
  // line events
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_operation,
  input  wire logic [7:0]  in_line_byte,
  // results
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_status,
  output logic [7:0]       out_data_byte,
  output logic [10:0]      out_byte_count,
  output logic             out_last
);
  import esr_pkg::*;

  logic               s1_valid_r;
  logic               s1_valid_nxt;
  op_t                s1_op_r;
  logic [BYTE_W-1:0]  s1_byte_r;
  logic               s1_fire;
  logic [COUNT_W-1:0] max_length_r;
  state_t             st_r;
  state_t             st_nxt;
  result_t            res;
  result_t            out_res_r;
  logic               out_valid_r;
  logic               out_valid_nxt;

  // handshakes
  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= MAX_LENGTH_RESET;
    end else if (cfg_wr_en) begin
      max_length_r <= cfg_wr_data;
    end
  end

  // input register
  assign s1_valid_nxt = (in_valid && in_ready) || (s1_valid_r && !s1_fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r   <= op_t'(in_operation);
      s1_byte_r <= in_line_byte;
    end
  end

  // step logic
  esr_step u_step (
    .op         (s1_op_r),
    .line_byte  (s1_byte_r),
    .max_length (max_length_r),
    .st         (st_r),
    .st_nxt     (st_nxt),
    .res        (res)
  );

  // subpacket state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= STATE_RESET;
    end else if (s1_fire) begin
      st_r <= st_nxt;
    end
  end

  // result register
  assign out_valid_nxt = s1_fire ? res.valid : (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res.valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_res_r.status;
  assign out_data_byte  = out_res_r.data;
  assign out_byte_count = out_res_r.count;
  assign out_last       = out_res_r.last;

  // checks
  a_last_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.last == (out_res_r.status != ST_DATA)))
    else $error("last flag disagrees with status");

  a_data_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.status == ST_DATA)) |-> (out_res_r.count != '0))
    else $error("data transaction with zero byte count");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && res.valid && res.last) |=>
      ((st_r.count == '0) && (st_r.phase == PH_DATA) && (st_r.crc == '0)))
    else $error("state not cleared after end of subpacket");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.count <= MAX_SUBPACKET)
    else $error("byte count beyond subpacket cap");

  a_stage_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_valid_r) |=> !($past(s1_valid_r) && s1_valid_r &&
      $stable(s1_op_r) && $stable(s1_byte_r) && !$past(in_ready)))
    else $error("input stage stalled with empty result register");

endmodule
`default_nettype wire

>>> tb/sv/esr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esr_checker: result checker for the escaped subpacket receiver
// Follows every accepted line event and every max_length write, works out
// the results the receiver owes, and compares each result transaction with
// the oldest one still due.
// ----------------------------------------------------------------------------
module esr_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [10:0] cfg_wr_data,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [1:0]  in_operation,
  input  wire logic [7:0]  in_line_byte,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [3:0]  out_status,
  input  wire logic [7:0]  out_data_byte,
  input  wire logic [10:0] out_byte_count,
  input  wire logic        out_last,
  output int               fail_count,
  output int               pending_results
);
  import esr_pkg::*;

  localparam int         REPORT_LIMIT    = 10;
  localparam logic [1:0] CANCEL_RUN_FULL = 2'd3;
  localparam logic [1:0] CRC_BYTES_TOTAL = 2'd2;

  // what an unescaped line symbol turns out to be
  typedef enum logic [1:0] {
    SYM_DATA,
    SYM_END,
    SYM_BAD
  } symbol_t;

  typedef struct packed {
    status_t            status;
    logic [BYTE_W-1:0]  data;
    logic [COUNT_W-1:0] count;
    logic               last;
  } rx_result_t;

  // receiver state as the accepted line events leave it
  phase_t             rx_phase;
  logic [1:0]         can_run;
  logic [CRC_W-1:0]   rx_crc;
  logic [COUNT_W-1:0] rx_count;
  logic [1:0]         rx_end_kind;
  logic [1:0]         crc_bytes_got;
  logic [COUNT_W-1:0] max_length;

  rx_result_t rx_results_due[$];
  rx_result_t got_result;
  rx_result_t want_result;
  int         mismatches = 0;

  // crc-16, poly 0x1021, msb first
  function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] r;
    r = crc ^ {b, 8'h00};
    repeat (8) r = r[CRC_W-1] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    return r;
  endfunction

  task automatic clear_subpacket();
    rx_phase      = PH_DATA;
    can_run       = '0;
    rx_crc        = '0;
    rx_count      = '0;
    rx_end_kind   = '0;
    crc_bytes_got = '0;
  endtask

  task automatic note_result(input status_t status, input logic [BYTE_W-1:0] data,
                             input logic last);
    rx_result_t r;
    r = '{status: status, data: data, count: rx_count, last: last};
    rx_results_due.push_back(r);
  endtask

  // any end of a subpacket reports the count and starts over
  task automatic end_subpacket(input status_t status);
    note_result(status, '0, 1'b1);
    clear_subpacket();
  endtask

  task automatic take_symbol(input symbol_t kind, input logic [BYTE_W-1:0] val,
                             input logic in_crc);
    logic [COUNT_W-1:0] limit;
    limit = (max_length > MAX_SUBPACKET) ? MAX_SUBPACKET : max_length;
    case (kind)
      SYM_BAD: begin
        end_subpacket(ST_BADESC);
      end
      // end code: crc continues, crc byte collection starts over
      SYM_END: begin
        rx_crc        = crc16_byte(rx_crc, {END_PREFIX, val[1:0]});
        rx_end_kind   = val[1:0];
        crc_bytes_got = '0;
        rx_phase      = PH_CRC;
      end
      default: begin
        if (in_crc) begin
          rx_crc        = crc16_byte(rx_crc, val);
          crc_bytes_got = crc_bytes_got + 2'd1;
          rx_phase      = PH_CRC;
          if (crc_bytes_got == CRC_BYTES_TOTAL) begin
            if (rx_crc != '0) begin
              end_subpacket(ST_BADCRC);
            end else begin
              end_subpacket(status_t'(ST_CRCE + {2'b00, rx_end_kind}));
            end
          end
        end else begin
          rx_phase = PH_DATA;
          if (rx_count >= limit) begin
            end_subpacket(ST_LONG);
          end else begin
            rx_count = rx_count + COUNT_W'(1);
            rx_crc   = crc16_byte(rx_crc, val);
            note_result(ST_DATA, val, 1'b0);
          end
        end
      end
    endcase
  endtask

  task automatic decode_line_event(input op_t op, input logic [BYTE_W-1:0] b);
    logic              in_crc;
    symbol_t           kind;
    logic [BYTE_W-1:0] val;
    in_crc = (rx_phase == PH_CRC) || (rx_phase == PH_CRC_ESC);
    case (op)
      OP_TIMEOUT: end_subpacket(ST_TIMEOUT);
      OP_CARRIER: end_subpacket(ST_CARRIER);
      OP_BYTE: begin
        if (rx_phase == PH_DATA_ESC || rx_phase == PH_CRC_ESC) begin
          // cans after an escape count toward a cancel
          if (b == ESC_BYTE) begin
            if (can_run == CANCEL_RUN_FULL) begin
              end_subpacket(ST_CANCEL);
            end else begin
              can_run = can_run + 2'd1;
            end
          end else begin
            can_run = '0;
            val     = '0;
            if (b[7:2] == END_PREFIX) begin
              kind = SYM_END;
              val  = {6'd0, b[1:0]};
            end else if (b == CODE_RUB0) begin
              kind = SYM_DATA;
              val  = VAL_RUB0;
            end else if (b == CODE_RUB1) begin
              kind = SYM_DATA;
              val  = VAL_RUB1;
            end else if ((b & CLASS_MASK) == CLASS_CTRL) begin
              kind = SYM_DATA;
              val  = b ^ CTRL_XOR;
            end else begin
              kind = SYM_BAD;
            end
            take_symbol(kind, val, in_crc);
          end
        end else if (b == ESC_BYTE) begin
          rx_phase = in_crc ? PH_CRC_ESC : PH_DATA_ESC;
          can_run  = '0;
        end else begin
          take_symbol(SYM_DATA, b, in_crc);
        end
      end
      // unused code leaves everything as it is
      default: ;
    endcase
  endtask

  // follow the channels and compare
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_subpacket();
      max_length = MAX_LENGTH_RESET;
      rx_results_due.delete();
    end else begin
      if (cfg_wr_en) begin
        max_length = cfg_wr_data;
      end
      if (in_valid && in_ready) begin
        decode_line_event(op_t'(in_operation), in_line_byte);
      end
      if (out_valid && out_ready) begin
        got_result = '{status: status_t'(out_status), data: out_data_byte,
                       count: out_byte_count, last: out_last};
        if (rx_results_due.size() == 0) begin
          if (mismatches < REPORT_LIMIT) begin
            $display("%0t: unexpected result status %0d data %02h count %0d last %0b",
                     $realtime, got_result.status, got_result.data, got_result.count,
                     got_result.last);
          end
          mismatches++;
        end else begin
          want_result = rx_results_due.pop_front();
          if (got_result !== want_result) begin
            if (mismatches < REPORT_LIMIT) begin
              $display("%0t: result mismatch, expected status %0d data %02h count %0d last %0b",
                       $realtime, want_result.status, want_result.data, want_result.count,
                       want_result.last);
              $display("%0t:                  actual status %0d data %02h count %0d last %0b",
                       $realtime, got_result.status, got_result.data, got_result.count,
                       got_result.last);
            end
            mismatches++;
          end
        end
      end
    end
    fail_count      <= mismatches;
    pending_results <= rx_results_due.size();
  end

endmodule

>>> tb/sv/tb_escaped_subpacket_receiver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_escaped_subpacket_receiver_top: testbench of the escaped subpacket receiver
// Sends escaped subpackets with good and broken crc, cancels, bad escapes,
// timeouts and carrier loss under several max_length settings and idling
// mixes; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_escaped_subpacket_receiver_top;
  import esr_pkg::*;

  localparam int CLK_HALF         = 2;
  localparam int STALL_LIMIT      = 2000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES    = 4;
  localparam int RANDOM_ITEMS     = 100;

  typedef enum logic [1:0] {
    KIND_CRCE,
    KIND_CRCG,
    KIND_CRCQ,
    KIND_CRCW
  } end_kind_t;

  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_CRC,
    FRAME_ABORTED
  } frame_end_t;

  logic        clk;
  logic        rst_n        = 1'b0;
  logic        cfg_wr_en    = 1'b0;
  logic [10:0] cfg_wr_data  = '0;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  op_t         in_operation = OP_BYTE;
  logic [7:0]  in_line_byte = '0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [3:0]  out_status;
  logic [7:0]  out_data_byte;
  logic [10:0] out_byte_count;
  logic        out_last;

  int          fail_count;
  int          pending_results;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          items_sent     = 0;
  int          quiet_cycles   = 0;
  bit          long_hold_req  = 1'b0;
  logic [15:0] tx_crc         = '0;

  escaped_subpacket_receiver_top DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_line_byte   (in_line_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_data_byte  (out_data_byte),
    .out_byte_count (out_byte_count),
    .out_last       (out_last)
  );

  esr_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_line_byte    (in_line_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_data_byte   (out_data_byte),
    .out_byte_count  (out_byte_count),
    .out_last        (out_last),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // receiver side: random stalls, one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold_req = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("escaped_subpacket_receiver_top test failed");
      $finish;
    end
  end

  // crc-16 for building the crc bytes of a subpacket
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {b, 8'h00};
    repeat (8) r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    return r;
  endfunction

  // one line event transaction, with random idle cycles before it
  task automatic send_event(input op_t op, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_line_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op != OP_UNUSED) begin
      items_sent++;
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_event(OP_BYTE, b);
  endtask

  // line encoding of one byte, escaped where required or asked
  task automatic send_coded(input logic [7:0] v, input bit want_esc);
    if (v == ESC_BYTE || (want_esc && v[6:5] == 2'b00)) begin
      send_byte(ESC_BYTE);
      send_byte(v ^ CTRL_XOR);
    end else if (want_esc && v == VAL_RUB0) begin
      send_byte(ESC_BYTE);
      send_byte(CODE_RUB0);
    end else if (want_esc && v == VAL_RUB1) begin
      send_byte(ESC_BYTE);
      send_byte(CODE_RUB1);
    end else begin
      send_byte(v);
    end
  endtask

  task automatic send_data_byte(input logic [7:0] v, input bit want_esc);
    tx_crc = crc16_byte(tx_crc, v);
    send_coded(v, want_esc);
  endtask

  // escaped end code and the two crc bytes, one crc bit flipped if asked
  task automatic close_frame(input end_kind_t kind, input bit corrupt);
    logic [15:0] c;
    send_byte(ESC_BYTE);
    send_byte({END_PREFIX, kind});
    c = crc16_byte(tx_crc, {END_PREFIX, kind});
    if (corrupt) begin
      c = c ^ (16'h0001 << $urandom_range(15));
    end
    send_coded(c[15:8], 1'($urandom_range(1)));
    send_coded(c[7:0], 1'($urandom_range(1)));
    tx_crc = '0;
  endtask

  task automatic send_frame(input int n_data, input frame_end_t ending);
    logic [7:0] v;
    tx_crc = '0;
    repeat (n_data) begin
      // lean on bytes that need or allow escaping
      case ($urandom_range(11))
        0:       v = ESC_BYTE;
        1:       v = VAL_RUB0;
        2:       v = VAL_RUB1;
        3:       v = 8'($urandom_range(31));
        default: v = 8'($urandom);
      endcase
      send_data_byte(v, 1'($urandom_range(1)));
    end
    if (ending == FRAME_ABORTED) begin
      send_event(op_t'($urandom_range(1) ? OP_TIMEOUT : OP_CARRIER), 8'($urandom));
      tx_crc = '0;
    end else begin
      close_frame(end_kind_t'($urandom_range(3)), ending == FRAME_BAD_CRC);
    end
  endtask

  // broken sequences, always closed by a timeout or carrier loss
  task automatic noise_burst();
    logic [7:0] code;
    repeat ($urandom_range(4, 1)) begin
      case ($urandom_range(6))
        0: send_byte(8'($urandom));
        1: begin
          send_byte(ESC_BYTE);
          send_byte(8'($urandom));
        end
        // escape and a run of cans, sometimes cut short by another byte
        2: begin
          send_byte(ESC_BYTE);
          repeat ($urandom_range(5, 1)) send_byte(ESC_BYTE);
          if ($urandom_range(1)) begin
            send_byte(8'($urandom));
          end
        end
        // escape code outside every valid class
        3: begin
          code = 8'($urandom);
          if (code[6:5] == 2'b10) begin
            code[6] = 1'b0;
          end
          if (code == ESC_BYTE || code[7:3] == END_PREFIX[5:1]) begin
            code[7] = 1'b1;
          end
          send_byte(ESC_BYTE);
          send_byte(code);
        end
        4: send_event(op_t'($urandom_range(1) ? OP_TIMEOUT : OP_CARRIER), 8'($urandom));
        5: send_event(OP_UNUSED, 8'($urandom));
        // end code followed by partial or odd crc bytes
        default: begin
          send_byte(ESC_BYTE);
          send_byte({END_PREFIX, 2'($urandom)});
          repeat ($urandom_range(3)) send_byte(8'($urandom));
        end
      endcase
    end
    send_event(op_t'($urandom_range(1) ? OP_TIMEOUT : OP_CARRIER), 8'($urandom));
    tx_crc = '0;
  endtask

  task automatic run_random(input int n_items);
    int stop_at;
    int pick;
    int n_data;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick   = $urandom_range(99);
      n_data = ($urandom_range(3) == 0) ? $urandom_range(40, 9) : $urandom_range(8);
      if (pick < 65) begin
        send_frame(n_data, FRAME_GOOD);
      end else if (pick < 75) begin
        send_frame(n_data, FRAME_BAD_CRC);
      end else if (pick < 85) begin
        send_frame(n_data, FRAME_ABORTED);
      end else begin
        noise_burst();
      end
    end
  endtask

  // wait until every result is in and the pipeline has emptied
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_length(input logic [10:0] v);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // stimulus and verdict
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // zero length: the first data byte is already too long
    write_max_length(11'd0);
    send_byte(8'h41);
    write_max_length(11'd1);
    send_byte(8'h00);
    send_byte(8'h01);
    write_max_length(MAX_LENGTH_RESET);

    // unused operation is ignored
    send_event(OP_UNUSED, 8'hff);

    // good subpacket with can, rubout and 0xff escapes
    tx_crc = '0;
    send_data_byte(ESC_BYTE, 1'b1);
    send_data_byte(VAL_RUB0, 1'b1);
    send_data_byte(VAL_RUB1, 1'b1);
    close_frame(KIND_CRCE, 1'b0);

    // end code among crc bytes restarts crc collection
    send_byte(ESC_BYTE);
    send_byte({END_PREFIX, KIND_CRCG});
    send_byte(8'h12);
    send_byte(ESC_BYTE);
    send_byte({END_PREFIX, KIND_CRCQ});
    send_event(OP_TIMEOUT, 8'h00);

    // escape and four cans cancel
    repeat (5) send_byte(ESC_BYTE);

    // escape, two cans, then a code decodes normally
    repeat (3) send_byte(ESC_BYTE);
    send_byte(8'h41);

    // bad escape, then carrier loss during an escape
    send_byte(ESC_BYTE);
    send_byte(8'h00);
    send_byte(ESC_BYTE);
    send_event(OP_CARRIER, 8'haa);

    // no idling; long receiver hold while the sender keeps offering
    write_max_length(11'h7ff);
    long_hold_req = 1'b1;
    run_random(RANDOM_ITEMS);

    // sender mostly idle
    write_max_length(11'd12);
    send_idle_pct = 85;
    run_random(RANDOM_ITEMS);

    // receiver mostly stalled
    write_max_length(MAX_LENGTH_RESET);
    send_idle_pct  = 0;
    recv_stall_pct = 85;
    run_random(RANDOM_ITEMS);

    // both sides idling now and then
    write_max_length(11'($urandom_range(40, 1)));
    send_idle_pct  = 27;
    recv_stall_pct = 27;
    run_random(RANDOM_ITEMS);

    drain_results();
    if (fail_count == 0) begin
      $display("escaped_subpacket_receiver_top test passed");
    end else begin
      $display("escaped_subpacket_receiver_top test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/esr_pkg.sv
hw/rtl/esr_step.sv
hw/rtl/escaped_subpacket_receiver_top.sv
tb/sv/esr_checker.sv
tb/sv/tb_escaped_subpacket_receiver_top.sv
